>>> src/iss_pkg.sv
package iss_pkg;

    localparam int unsigned DATA_W = 32;

    typedef logic signed [DATA_W-1:0] data_t;

    typedef enum logic
    {
        ST_LOAD  = 1'b0,
        ST_DRAIN = 1'b1
    } state_t;

    typedef struct packed
    {
        logic ins;
        logic drain;
    } cell_ctrl_t;

endpackage

>>> src/iss_cell.sv
module iss_cell
    import iss_pkg::*;
(
    input  logic       clk,
    input  cell_ctrl_t ctrl,
    input  logic       valid,
    input  data_t      new_value,
    input  logic       left_gt,
    input  data_t      left_value,
    input  data_t      right_value,
    output data_t      value,
    output logic       gt
);

    data_t value_reg;
    data_t value_next;

    // An empty cell counts as greater than any value.
    assign gt    = !valid || (value_reg > new_value);
    assign value = value_reg;

    always_comb
    begin
        value_next = value_reg;
        if (ctrl.drain)
        begin
            value_next = right_value;
        end
        else if (ctrl.ins && gt)
        begin
            value_next = left_gt ? left_value : new_value;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

>>> src/insertion_sorter_unit.sv
// Loading: one beat per cycle; a value accepted while not full enters the row in that cycle.
// Sorting: the last input beat starts the drain; the first result is valid the next cycle.
// Draining: one result per cycle while m_axis_tready is high, from the lowest cell;
// no input is taken while results are pending.
// Reset clears the fill count, the overflow flag and the state; cell contents stay undefined.
module insertion_sorter_unit
    import iss_pkg::*;
#(
    parameter int unsigned DEPTH = 64
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [DATA_W-1:0] s_axis_tdata,   // [31:0] value
    input  logic              s_axis_tlast,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [DATA_W-1:0] m_axis_tdata,   // [31:0] sorted_value
    output logic              m_axis_tlast,
    output logic              m_axis_tuser    // [0] overflow
);

    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             dropped_reg;
    logic             dropped_next;
    cell_ctrl_t       ctrl;
    logic             in_beat;
    logic             out_beat;
    logic             full;
    data_t            new_value;
    data_t            cell_value [DEPTH];
    logic             cell_gt    [DEPTH];

    assign new_value = data_t'(s_axis_tdata);
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign in_beat   = s_axis_tvalid && s_axis_tready;
    assign out_beat  = m_axis_tvalid && m_axis_tready;

    assign m_axis_tdata = cell_value[0];
    assign m_axis_tlast = (count_reg == CNT_W'(1));
    assign m_axis_tuser = dropped_reg;

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            logic  left_gt;
            data_t left_value;
            data_t right_value;

            if (i == 0)
            begin : g_first
                assign left_gt    = 1'b0;
                assign left_value = new_value;
            end
            else
            begin : g_mid
                assign left_gt    = cell_gt[i-1];
                assign left_value = cell_value[i-1];
            end

            if (i == DEPTH - 1)
            begin : g_end
                assign right_value = cell_value[i];
            end
            else
            begin : g_inner
                assign right_value = cell_value[i+1];
            end

            iss_cell u_cell
            (
                .clk         (clk),
                .ctrl        (ctrl),
                .valid       (count_reg > CNT_W'(i)),
                .new_value   (new_value),
                .left_gt     (left_gt),
                .left_value  (left_value),
                .right_value (right_value),
                .value       (cell_value[i]),
                .gt          (cell_gt[i])
            );
        end
    endgenerate

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        dropped_next  = dropped_reg;
        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;
        ctrl.ins      = 1'b0;
        ctrl.drain    = 1'b0;
        case (state_reg)
            ST_LOAD:
            begin
                s_axis_tready = 1'b1;
                if (in_beat)
                begin
                    if (full)
                    begin
                        dropped_next = 1'b1;
                    end
                    else
                    begin
                        ctrl.ins   = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                    if (s_axis_tlast)
                    begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN:
            begin
                m_axis_tvalid = 1'b1;
                if (out_beat)
                begin
                    ctrl.drain = 1'b1;
                    count_next = count_reg - CNT_W'(1);
                    if (m_axis_tlast)
                    begin
                        dropped_next = 1'b0;
                        state_next   = ST_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_LOAD;
            count_reg   <= '0;
            dropped_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            dropped_reg <= dropped_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("fill count beyond depth");

    a_drain_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DRAIN |-> count_reg != '0)
        else $error("drain with empty store");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("load and drain at once");

    a_drop_flag: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat && full |=> dropped_reg || $past(s_axis_tlast) == 1'b0 || state_reg == ST_DRAIN)
        else $error("dropped beat not flagged");

    a_back_to_load: assert property (@(posedge clk) disable iff (!rst_n)
        out_beat && m_axis_tlast |=> s_axis_tready && count_reg == '0 && !dropped_reg)
        else $error("state not cleared after final result");

endmodule
